// ===== rtl/core/gaussian_polar_box_muller_assert.svh =====
// ----------------------------------------------------------------------------
// Gaussian generator assertion macros
// Shorthands for the concurrent checks in the Gaussian generator RTL.
// ----------------------------------------------------------------------------
`ifndef GAUSSIAN_POLAR_BOX_MULLER_ASSERT_SVH
`define GAUSSIAN_POLAR_BOX_MULLER_ASSERT_SVH

// same-cycle implication, disabled during reset
`define GPBM_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("gpbm same-cycle check failed");

// next-cycle implication, disabled during reset
`define GPBM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("gpbm next-cycle check failed");

`endif

// ===== rtl/core/gpbm_pkg.sv =====
// ----------------------------------------------------------------------------
// gpbm_pkg
// Shared widths, register indexes and pipeline word types of the Gaussian
// generator.
// ----------------------------------------------------------------------------
`default_nettype none

package gpbm_pkg;

    localparam int U_IN_W     = 16;
    localparam int SAMPLE_W   = 32;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 32;
    localparam int EXP_W      = 7;
    localparam int LOG_STEPS  = 32;
    localparam int ROOT_STEPS = 17;
    localparam int ROOT_W     = 34;
    localparam int YMAG_W     = 15;

    localparam logic [CFG_IDX_W-1:0] REG_MEAN    = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_STD_DEV = 8'd1;

    localparam logic [31:0] STD_DEV_RESET = 32'h0001_0000;
    localparam logic [30:0] TWO_LN2_Q30   = 31'd1488522236;
    localparam logic [YMAG_W-1:0] YMAG_MAX = 15'd32767;

    // one log-squaring step plus one quotient bit for each lane
    typedef struct packed {
        logic [31:0]      m;
        logic [31:0]      frac;
        logic [EXP_W-1:0] e;
        logic [31:0]      wn;
        logic [31:0]      rem_a;
        logic [31:0]      rem_b;
        logic [32:0]      q_a;
        logic [32:0]      q_b;
        logic             neg_a;
        logic             neg_b;
    } t_iter;

    // digit-by-digit square root state for both lanes
    typedef struct packed {
        logic [ROOT_W-1:0] v_a;
        logic [ROOT_W-1:0] res_a;
        logic [ROOT_W-1:0] v_b;
        logic [ROOT_W-1:0] res_b;
        logic              neg_a;
        logic              neg_b;
    } t_root;

endpackage

`default_nettype wire

// ===== rtl/core/gpbm_if.sv =====
// ----------------------------------------------------------------------------
// gpbm channel interfaces
// Valid/ready channels for uniform pairs, Gaussian samples and register
// writes.
// ----------------------------------------------------------------------------
`default_nettype none

interface gpbm_in_if;
    logic                         valid;
    logic                         ready;
    logic [gpbm_pkg::U_IN_W-1:0]  uniform_a;
    logic [gpbm_pkg::U_IN_W-1:0]  uniform_b;
    modport source (output valid, output uniform_a, output uniform_b, input ready);
    modport sink   (input valid, input uniform_a, input uniform_b, output ready);
endinterface

interface gpbm_out_if;
    logic                          valid;
    logic                          ready;
    logic [gpbm_pkg::SAMPLE_W-1:0] sample;
    logic                          last;
    modport source (output valid, output sample, output last, input ready);
    modport sink   (input valid, input sample, input last, output ready);
endinterface

interface gpbm_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [gpbm_pkg::CFG_IDX_W-1:0]  index;
    logic [gpbm_pkg::CFG_DATA_W-1:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/gpbm_log_div_stage.sv =====
// ----------------------------------------------------------------------------
// gpbm_log_div_stage
// One pipeline stage: one squaring step of the log2 mantissa and one
// restoring-division quotient bit for each of the two lanes.
// ----------------------------------------------------------------------------
`default_nettype none

module gpbm_log_div_stage (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  logic            i_valid,
    input  gpbm_pkg::t_iter i_d,
    output logic            o_valid,
    output gpbm_pkg::t_iter o_d
);

    logic [63:0]     sq;
    logic [32:0]     p;
    logic [32:0]     sh_a;
    logic [32:0]     sh_b;
    logic            take_a;
    logic            take_b;
    gpbm_pkg::t_iter n_d;
    logic            r_valid;
    gpbm_pkg::t_iter r_d;

    always_comb begin
        sq     = i_d.m * i_d.m;
        p      = sq[63:31];
        sh_a   = {i_d.rem_a, 1'b0};
        sh_b   = {i_d.rem_b, 1'b0};
        take_a = sh_a >= {1'b0, i_d.wn};
        take_b = sh_b >= {1'b0, i_d.wn};
        n_d    = i_d;
        // renormalize when the square reaches 2.0 and record the bit
        n_d.m     = p[32] ? p[32:1] : p[31:0];
        n_d.frac  = {i_d.frac[30:0], p[32]};
        n_d.rem_a = take_a ? 32'(sh_a - {1'b0, i_d.wn}) : sh_a[31:0];
        n_d.rem_b = take_b ? 32'(sh_b - {1'b0, i_d.wn}) : sh_b[31:0];
        n_d.q_a   = {i_d.q_a[31:0], take_a};
        n_d.q_b   = {i_d.q_b[31:0], take_b};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_d <= n_d;
        end
    end

    assign o_valid = r_valid;
    assign o_d     = r_d;

endmodule

`default_nettype wire

// ===== rtl/core/gpbm_root_stage.sv =====
// ----------------------------------------------------------------------------
// gpbm_root_stage
// One pipeline stage of the digit-by-digit integer square root, both lanes.
// ----------------------------------------------------------------------------
`default_nettype none

module gpbm_root_stage #(
    parameter int BIT_POS = 0
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  logic            i_valid,
    input  gpbm_pkg::t_root i_d,
    output logic            o_valid,
    output gpbm_pkg::t_root o_d
);

    localparam logic [gpbm_pkg::ROOT_W-1:0] BitVal =
        gpbm_pkg::ROOT_W'(1) << BIT_POS;

    logic [gpbm_pkg::ROOT_W-1:0] try_a;
    logic [gpbm_pkg::ROOT_W-1:0] try_b;
    gpbm_pkg::t_root             n_d;
    logic                        r_valid;
    gpbm_pkg::t_root             r_d;

    always_comb begin
        try_a = i_d.res_a + BitVal;
        try_b = i_d.res_b + BitVal;
        n_d   = i_d;
        if (i_d.v_a >= try_a) begin
            n_d.v_a   = i_d.v_a - try_a;
            n_d.res_a = (i_d.res_a >> 1) + BitVal;
        end else begin
            n_d.res_a = i_d.res_a >> 1;
        end
        if (i_d.v_b >= try_b) begin
            n_d.v_b   = i_d.v_b - try_b;
            n_d.res_b = (i_d.res_b >> 1) + BitVal;
        end else begin
            n_d.res_b = i_d.res_b >> 1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_d <= n_d;
        end
    end

    assign o_valid = r_valid;
    assign o_d     = r_d;

endmodule

`default_nettype wire

// ===== rtl/core/gaussian_polar_box_muller.sv =====
// ----------------------------------------------------------------------------
// gaussian_polar_box_muller
// Polar Box-Muller Gaussian generator: one uniform pair in, two normal
// samples (mean + y * std_dev, Q16.16, saturated) out, or none on rejection.
// ----------------------------------------------------------------------------
// Usage:
//   i_uniform takes one uniform pair per word; i_cfg writes mean (index 0)
//   and std_dev (index 1) and is always ready; o_sample gives the two
//   samples of an accepted pair in order, the second with last set.
//   Pairs on or outside the unit circle, or at its center, produce no word.
//   The second sample of a pair follows as soon as the first is taken. The
//   pipeline has 61 register stages: a 32-stage log2 squaring chain that
//   runs beside two bit-per-stage dividers, then a 17-stage square root.
//   Throughput: one pair per cycle into the pipeline unless the output
//   register still owes a word; the output register hands out one sample
//   per cycle while o_sample is ready, so an accepted pair holds the
//   pipeline until its second sample is taken, and a rejected pair does not.
//   When o_sample stalls the whole pipeline holds; i_uniform.ready drops
//   and no word is lost or repeated.
//   Reset (i_rst_n low, synchronous) empties the pipeline and sets mean to
//   0.0 and std_dev to 1.0.
// ----------------------------------------------------------------------------
`default_nettype none

`include "gaussian_polar_box_muller_assert.svh"

module gaussian_polar_box_muller #(
    parameter int UNIFORM_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    gpbm_in_if.sink     i_uniform,
    gpbm_out_if.source  o_sample,
    gpbm_cfg_if.sink    i_cfg
);

    localparam int B     = UNIFORM_BITS;
    localparam int SQ_W  = 2 * B;
    localparam int W_W   = 2 * B + 1;
    localparam int NORM_W = W_W + 31;
    localparam logic [gpbm_pkg::EXP_W-1:0] TwoB = gpbm_pkg::EXP_W'(2 * B);
    localparam int NLOG  = gpbm_pkg::LOG_STEPS;
    localparam int NROOT = gpbm_pkg::ROOT_STEPS;
    localparam int RW    = gpbm_pkg::ROOT_W;

    // configuration
    logic signed [31:0] r_mean;
    logic [31:0]        r_std_dev;

    logic en;

    // stage 1: fold to magnitude and sign
    logic [B-1:0] ua;
    logic [B-1:0] ub;
    logic [B:0]   full;
    logic [B:0]   ma;
    logic [B:0]   mb;
    logic         na;
    logic         nb;
    logic         r_v1;
    logic [B-1:0] r1_ma;
    logic [B-1:0] r1_mb;
    logic         r1_na;
    logic         r1_nb;

    // stage 2: squares
    logic            r_v2;
    logic [SQ_W-1:0] r2_sa;
    logic [SQ_W-1:0] r2_sb;
    logic            r2_na;
    logic            r2_nb;

    // stage 3: radius and rejection
    logic [W_W-1:0]  w3;
    logic            r_v3;
    logic [W_W-1:0]  r3_w;
    logic [SQ_W-1:0] r3_sa;
    logic [SQ_W-1:0] r3_sb;
    logic            r3_na;
    logic            r3_nb;

    // stage 4: top bit
    logic [gpbm_pkg::EXP_W-1:0] e4;
    logic                       r_v4;
    logic [gpbm_pkg::EXP_W-1:0] r4_e;
    logic [W_W-1:0]             r4_w;
    logic [SQ_W-1:0]            r4_sa;
    logic [SQ_W-1:0]            r4_sb;
    logic                       r4_na;
    logic                       r4_nb;

    // stage 5: normalize
    logic [gpbm_pkg::EXP_W-1:0] sh5;
    logic [NORM_W-1:0]          norm5;
    logic                       r_v5;
    logic [31:0]                r5_m;
    logic [gpbm_pkg::EXP_W-1:0] r5_e;
    logic [31:0]                r5_wn;
    logic [31:0]                r5_an_a;
    logic [31:0]                r5_an_b;
    logic                       r5_na;
    logic                       r5_nb;

    // stage 6 and the log/divide chain
    logic            hi_a;
    logic            hi_b;
    gpbm_pkg::t_iter n_it0;
    logic            it_v [NLOG+1];
    gpbm_pkg::t_iter it_d [NLOG+1];

    // log to L24
    gpbm_pkg::t_iter it_last;
    logic [39:0]     t_calc;
    logic            r_vt;
    logic [39:0]     r_t;
    logic [32:0]     rt_qa;
    logic [32:0]     rt_qb;
    logic            rt_na;
    logic            rt_nb;
    logic [63:0]     l_prod;
    logic            r_vl;
    logic [31:0]     r_l24;
    logic [32:0]     rl_qa;
    logic [32:0]     rl_qb;
    logic            rl_na;
    logic            rl_nb;
    logic [64:0]     y_prod_a;
    logic [64:0]     y_prod_b;
    gpbm_pkg::t_root n_root0;

    // square root chain
    logic            rt_v [NROOT+1];
    gpbm_pkg::t_root rt_d [NROOT+1];

    // round, scale, offset
    gpbm_pkg::t_root              root_last;
    logic [RW-1:0]                s_a;
    logic [RW-1:0]                s_b;
    logic                         r_vr;
    logic [gpbm_pkg::YMAG_W-1:0]  r_ym_a;
    logic [gpbm_pkg::YMAG_W-1:0]  r_ym_b;
    logic                         rr_na;
    logic                         rr_nb;
    logic [47:0]                  q_prod_a;
    logic [47:0]                  q_prod_b;
    logic                         r_vq;
    logic [35:0]                  r_q_a;
    logic [35:0]                  r_q_b;
    logic                         rq_na;
    logic                         rq_nb;

    // output pair register
    logic        r_ovalid;
    logic        r_phase;
    logic [31:0] r_sa;
    logic [31:0] r_sb;

    function automatic logic [31:0] offset_sat(input logic signed [31:0] mean_v,
                                               input logic [35:0] q,
                                               input logic neg);
        logic signed [37:0] m_x;
        logic signed [37:0] q_x;
        logic signed [37:0] sum;
        m_x = {{6{mean_v[31]}}, mean_v};
        q_x = {2'b00, q};
        sum = neg ? (m_x - q_x) : (m_x + q_x);
        if (sum > 38'sh0_7FFF_FFFF) begin
            offset_sat = 32'h7FFF_FFFF;
        end else if (sum < -38'sh0_8000_0000) begin
            offset_sat = 32'h8000_0000;
        end else begin
            offset_sat = sum[31:0];
        end
    endfunction

    // ---------------------------------------------------------------- config
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mean    <= '0;
            r_std_dev <= gpbm_pkg::STD_DEV_RESET;
        end else if (i_cfg.valid && i_cfg.ready) begin
            unique case (i_cfg.index)
                gpbm_pkg::REG_MEAN:    r_mean    <= signed'(i_cfg.data);
                gpbm_pkg::REG_STD_DEV: r_std_dev <= i_cfg.data;
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------- pipeline enable
    // advance unless the output register still owes a word
    assign en              = !r_ovalid || (r_phase && o_sample.ready);
    assign i_uniform.ready = en;

    // ---------------------------------------------------------------- stage 1
    always_comb begin
        ua   = B'(i_uniform.uniform_a);
        ub   = B'(i_uniform.uniform_b);
        full = {1'b1, {B{1'b0}}};
        na   = ~ua[B-1];
        nb   = ~ub[B-1];
        ma   = na ? (full - {ua, 1'b0}) : ({ua, 1'b0} - full);
        mb   = nb ? (full - {ub, 1'b0}) : ({ub, 1'b0} - full);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
        end else if (en) begin
            // a zero sample gives x = -1: drop the pair
            r_v1 <= i_uniform.valid && !ma[B] && !mb[B];
            r_v2 <= r_v1;
            r_v3 <= r_v2 && !w3[W_W-1] && (w3 != '0);
            r_v4 <= r_v3;
            r_v5 <= r_v4;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_ma <= ma[B-1:0];
            r1_mb <= mb[B-1:0];
            r1_na <= na;
            r1_nb <= nb;

            r2_sa <= r1_ma * r1_ma;
            r2_sb <= r1_mb * r1_mb;
            r2_na <= r1_na;
            r2_nb <= r1_nb;

            r3_w  <= w3;
            r3_sa <= r2_sa;
            r3_sb <= r2_sb;
            r3_na <= r2_na;
            r3_nb <= r2_nb;

            r4_e  <= e4;
            r4_w  <= r3_w;
            r4_sa <= r3_sa;
            r4_sb <= r3_sb;
            r4_na <= r3_na;
            r4_nb <= r3_nb;

            r5_m    <= norm5[31:0];
            r5_e    <= r4_e;
            r5_wn   <= 32'(r4_w >> sh5);
            r5_an_a <= 32'(r4_sa >> sh5);
            r5_an_b <= 32'(r4_sb >> sh5);
            r5_na   <= r4_na;
            r5_nb   <= r4_nb;
        end
    end

    assign w3 = {1'b0, r2_sa} + {1'b0, r2_sb};

    always_comb begin
        e4 = '0;
        for (int k = 0; k < W_W; k++) begin
            if (r3_w[k]) begin
                e4 = gpbm_pkg::EXP_W'(k);
            end
        end
    end

    always_comb begin
        // squeeze W into 32 bits for the divider when it is wider
        sh5   = (r4_e >= gpbm_pkg::EXP_W'(32)) ? (r4_e - gpbm_pkg::EXP_W'(31)) : '0;
        norm5 = {r4_w, 31'b0} >> r4_e;
    end

    // ---------------------------------------------------- stage 6 and chain
    always_comb begin
        hi_a        = r5_an_a >= r5_wn;
        hi_b        = r5_an_b >= r5_wn;
        n_it0.m     = r5_m;
        n_it0.frac  = '0;
        n_it0.e     = r5_e;
        n_it0.wn    = r5_wn;
        n_it0.rem_a = hi_a ? (r5_an_a - r5_wn) : r5_an_a;
        n_it0.rem_b = hi_b ? (r5_an_b - r5_wn) : r5_an_b;
        n_it0.q_a   = {32'b0, hi_a};
        n_it0.q_b   = {32'b0, hi_b};
        n_it0.neg_a = r5_na;
        n_it0.neg_b = r5_nb;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            it_v[0] <= 1'b0;
        end else if (en) begin
            it_v[0] <= r_v5;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            it_d[0] <= n_it0;
        end
    end

    for (genvar g = 0; g < NLOG; g++) begin : g_log
        gpbm_log_div_stage u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_valid (it_v[g]),
            .i_d     (it_d[g]),
            .o_valid (it_v[g+1]),
            .o_d     (it_d[g+1])
        );
    end

    // ------------------------------------------------------- log to L24
    assign it_last = it_d[NLOG];
    assign t_calc  = (40'(TwoB - it_last.e) << 32) - 40'(it_last.frac);
    assign l_prod  = 64'(r_t[38:6]) * 64'(gpbm_pkg::TWO_LN2_Q30);
    assign y_prod_a = 65'(rl_qa) * 65'(r_l24);
    assign y_prod_b = 65'(rl_qb) * 65'(r_l24);

    always_comb begin
        n_root0.v_a   = RW'(y_prod_a[64:32]);
        n_root0.res_a = '0;
        n_root0.v_b   = RW'(y_prod_b[64:32]);
        n_root0.res_b = '0;
        n_root0.neg_a = rl_na;
        n_root0.neg_b = rl_nb;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vt    <= 1'b0;
            r_vl    <= 1'b0;
            rt_v[0] <= 1'b0;
        end else if (en) begin
            r_vt    <= it_v[NLOG];
            r_vl    <= r_vt;
            rt_v[0] <= r_vl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_t   <= t_calc;
            rt_qa <= it_last.q_a;
            rt_qb <= it_last.q_b;
            rt_na <= it_last.neg_a;
            rt_nb <= it_last.neg_b;

            r_l24 <= l_prod[63:32];
            rl_qa <= rt_qa;
            rl_qb <= rt_qb;
            rl_na <= rt_na;
            rl_nb <= rt_nb;

            rt_d[0] <= n_root0;
        end
    end

    for (genvar j = 0; j < NROOT; j++) begin : g_root
        gpbm_root_stage #(
            .BIT_POS (2 * (NROOT - 1 - j))
        ) u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_valid (rt_v[j]),
            .i_d     (rt_d[j]),
            .o_valid (rt_v[j+1]),
            .o_d     (rt_d[j+1])
        );
    end

    // ------------------------------------------------- round, scale, offset
    assign root_last = rt_d[NROOT];
    // round to nearest: bump when the remainder exceeds the root
    assign s_a = root_last.res_a + RW'(root_last.v_a > root_last.res_a);
    assign s_b = root_last.res_b + RW'(root_last.v_b > root_last.res_b);

    assign q_prod_a = 48'(r_ym_a) * 48'(r_std_dev) + 48'd2048;
    assign q_prod_b = 48'(r_ym_b) * 48'(r_std_dev) + 48'd2048;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vr <= 1'b0;
            r_vq <= 1'b0;
        end else if (en) begin
            r_vr <= rt_v[NROOT];
            r_vq <= r_vr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_ym_a <= (s_a > RW'(gpbm_pkg::YMAG_MAX)) ? gpbm_pkg::YMAG_MAX
                                                     : s_a[gpbm_pkg::YMAG_W-1:0];
            r_ym_b <= (s_b > RW'(gpbm_pkg::YMAG_MAX)) ? gpbm_pkg::YMAG_MAX
                                                     : s_b[gpbm_pkg::YMAG_W-1:0];
            rr_na  <= root_last.neg_a;
            rr_nb  <= root_last.neg_b;

            r_q_a <= q_prod_a[47:12];
            r_q_b <= q_prod_b[47:12];
            rq_na <= rr_na;
            rq_nb <= rr_nb;
        end
    end

    // ------------------------------------------------------- output pair
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
            r_phase  <= 1'b0;
        end else if (en) begin
            r_ovalid <= r_vq;
            r_phase  <= 1'b0;
        end else if (r_ovalid && !r_phase && o_sample.ready) begin
            r_phase <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_sa <= offset_sat(r_mean, r_q_a, rq_na);
            r_sb <= offset_sat(r_mean, r_q_b, rq_nb);
        end
    end

    assign o_sample.valid  = r_ovalid;
    assign o_sample.sample = r_phase ? r_sb : r_sa;
    assign o_sample.last   = r_phase;

    // ---------------------------------------------------------- assertions
    `GPBM_ASSERT_SAME(a_second_needs_pair, i_clk, i_rst_n, r_phase, r_ovalid)
    `GPBM_ASSERT_NEXT(a_first_then_second, i_clk, i_rst_n, r_ovalid && !r_phase && o_sample.ready, r_ovalid && r_phase)
    `GPBM_ASSERT_NEXT(a_second_ends_pair, i_clk, i_rst_n, r_ovalid && r_phase && o_sample.ready, !r_phase)
    `GPBM_ASSERT_NEXT(a_pair_lands, i_clk, i_rst_n, en && r_vq, r_ovalid && !r_phase)

endmodule

`default_nettype wire

// ===== sim/gaussian_polar_box_muller_checker.sv =====
// ----------------------------------------------------------------------------
// Gaussian generator sample checker
// Watches the pair, sample and register channels, works out the two samples
// of every accepted pair in fixed point and compares them in order.
// ----------------------------------------------------------------------------
`default_nettype none

module gaussian_polar_box_muller_checker (
    input  logic       i_clk,
    input  logic       i_rst_n,
    gpbm_in_if         pair_ch,
    gpbm_out_if        sample_ch,
    gpbm_cfg_if        cfg_ch,
    output int         o_errors,
    output int         o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic [31:0] sample;
        logic        last;
    } t_sample_word;

    t_sample_word sample_q[$];
    logic signed [63:0] mean_val;
    logic [31:0]        std_val;

    function automatic logic [63:0] int_sqrt(input logic [63:0] v);
        logic [63:0] res;
        logic [63:0] bitv;
        res  = 0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv >>= 2;
        while (bitv != 0) begin
            if (v >= res + bitv) begin
                v   = v - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv >>= 2;
        end
        return res;
    endfunction

    // |y| in Q3.12 from x^2, W and -2 ln w in Q24
    function automatic logic [63:0] gauss_magnitude(input logic [63:0] xsq, input logic [63:0] w,
                                                    input logic [63:0] l24);
        logic [63:0] r;
        logic [63:0] y2;
        logic [63:0] s;
        r  = (xsq << 32) / w;
        y2 = (r * l24) >> 32;
        s  = int_sqrt(y2);
        if (y2 - s * s > s) s++;
        return (s > 64'd32767) ? 64'd32767 : s;
    endfunction

    function automatic logic [31:0] scale_sample(input logic [63:0] ymag, input logic neg);
        logic [63:0]        q;
        logic signed [63:0] sum;
        q   = (ymag * {32'd0, std_val} + 64'd2048) >> 12;
        sum = neg ? mean_val - $signed(q) : mean_val + $signed(q);
        if (sum > 64'sd2147483647) sum = 64'sd2147483647;
        if (sum < -64'sd2147483648) sum = -64'sd2147483648;
        return sum[31:0];
    endfunction

    task automatic predict_pair(input logic [15:0] ua, input logic [15:0] ub);
        logic [63:0]  ma, mb, sa, sb, w, m, frac, t, l24;
        logic         na, nb;
        int           e;
        t_sample_word wd;
        na = ua < 16'h8000;
        nb = ub < 16'h8000;
        ma = na ? 64'd65536 - 2 * ua : 2 * ua - 64'd65536;
        mb = nb ? 64'd65536 - 2 * ub : 2 * ub - 64'd65536;
        if (ma >= 64'd65536 || mb >= 64'd65536) return;
        sa = ma * ma;
        sb = mb * mb;
        w  = sa + sb;
        // drop pairs on or outside the unit circle or at its center
        if (w >= (64'd1 << 32) || w == 0) return;
        e = 0;
        while (e < 63 && (w >> (e + 1)) != 0) e++;
        m    = (e >= 31) ? (w >> (e - 31)) : (w << (31 - e));
        frac = 0;
        for (int i = 0; i < 32; i++) begin
            m = (m * m) >> 31;
            if (m >= (64'd1 << 32)) begin
                m = m >> 1;
                frac[31 - i] = 1'b1;
            end
        end
        t   = (64'(32 - e) << 32) - frac;
        l24 = ((t >> 6) * 64'd1488522236) >> 32;
        wd.sample = scale_sample(gauss_magnitude(sa, w, l24), na);
        wd.last   = 1'b0;
        sample_q.push_back(wd);
        wd.sample = scale_sample(gauss_magnitude(sb, w, l24), nb);
        wd.last   = 1'b1;
        sample_q.push_back(wd);
    endtask

    always @(posedge i_clk) begin
        t_sample_word want;
        if (!i_rst_n) begin
            mean_val <= 0;
            std_val  <= gpbm_pkg::STD_DEV_RESET;
            o_errors <= 0;
        end else begin
            if (cfg_ch.valid && cfg_ch.ready) begin
                if (cfg_ch.index == gpbm_pkg::REG_MEAN) mean_val <= $signed(cfg_ch.data);
                else if (cfg_ch.index == gpbm_pkg::REG_STD_DEV) std_val <= cfg_ch.data;
            end
            if (sample_ch.valid && sample_ch.ready) begin
                if (sample_q.size() == 0) begin
                    if (o_errors < 10)
                        $display("unexpected sample word %h last %b", sample_ch.sample,
                                 sample_ch.last);
                    o_errors <= o_errors + 1;
                end else begin
                    want = sample_q.pop_front();
                    if (want.sample !== sample_ch.sample || want.last !== sample_ch.last) begin
                        if (o_errors < 10)
                            $display("sample mismatch: want %h last %b, got %h last %b",
                                     want.sample, want.last, sample_ch.sample, sample_ch.last);
                        o_errors <= o_errors + 1;
                    end
                end
            end
            if (pair_ch.valid && pair_ch.ready)
                predict_pair(pair_ch.uniform_a, pair_ch.uniform_b);
        end
    end

    assign o_pending = sample_q.size();

endmodule

`default_nettype wire

// ===== sim/gaussian_polar_box_muller_test.sv =====
// ----------------------------------------------------------------------------
// Gaussian generator regression
// Drives uniform pairs and register writes into the generator with random
// stalls on both sides; the checker predicts and compares every sample.
// ----------------------------------------------------------------------------
`default_nettype none

module gaussian_polar_box_muller_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STALL_LIMIT = 2000;

    logic i_clk;
    logic i_rst_n;
    logic calm;
    logic pair_took;
    logic cfg_took;
    int   errors;
    int   pending;
    int   hold_cnt;
    int   quiet_cnt;

    gpbm_in_if  pair_ch ();
    gpbm_out_if sample_ch ();
    gpbm_cfg_if cfg_ch ();

    gaussian_polar_box_muller u_top (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_uniform (pair_ch),
        .o_sample  (sample_ch),
        .i_cfg     (cfg_ch)
    );

    gaussian_polar_box_muller_checker u_check (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .pair_ch   (pair_ch),
        .sample_ch (sample_ch),
        .cfg_ch    (cfg_ch),
        .o_errors  (errors),
        .o_pending (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        pair_took <= pair_ch.valid && pair_ch.ready;
        cfg_took  <= cfg_ch.valid && cfg_ch.ready;
    end

    // sample sink: stall in bursts unless in the calm tail
    always @(negedge i_clk) begin
        if (hold_cnt > 0) begin
            sample_ch.ready <= 1'b0;
            hold_cnt <= hold_cnt - 1;
        end else if (!calm && $urandom_range(0, 7) == 0) begin
            sample_ch.ready <= 1'b0;
            hold_cnt <= $urandom_range(0, 7);
        end else begin
            sample_ch.ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (pair_ch.valid && pair_ch.ready) || (cfg_ch.valid && cfg_ch.ready)
            || (sample_ch.valid && sample_ch.ready)) begin
            quiet_cnt <= 0;
        end else if (quiet_cnt >= STALL_LIMIT) begin
            $display("gaussian_polar_box_muller regression: fail");
            $finish;
        end else begin
            quiet_cnt <= quiet_cnt + 1;
        end
    end

    task automatic send_pair(input logic [15:0] a, input logic [15:0] b);
        int gap;
        if (!calm && $urandom_range(0, 9) == 0) begin
            pair_ch.valid <= 1'b0;
            gap = $urandom_range(1, 8);
            repeat (gap) @(negedge i_clk);
        end
        pair_ch.valid     <= 1'b1;
        pair_ch.uniform_a <= a;
        pair_ch.uniform_b <= b;
        do @(negedge i_clk); while (!pair_took);
    endtask

    task automatic write_reg(input logic [gpbm_pkg::CFG_IDX_W-1:0] idx,
                             input logic [31:0] value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        do @(negedge i_clk); while (!cfg_took);
        cfg_ch.valid <= 1'b0;
    endtask

    // drain, then let rejected pairs clear the pipeline
    task automatic drain;
        pair_ch.valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (70) @(negedge i_clk);
    endtask

    task automatic random_pairs(input int count);
        logic [15:0] a, b;
        repeat (count) begin
            case ($urandom_range(0, 7))
                0: begin
                    // hug the center to reach large magnitudes
                    a = 16'h8000 + 16'($urandom_range(0, 64)) - 16'd32;
                    b = 16'h8000 + 16'($urandom_range(0, 64)) - 16'd32;
                end
                1: begin
                    a = 16'($urandom);
                    b = $urandom_range(0, 1) ? 16'h8000 : 16'h0000;
                end
                default: begin
                    a = 16'($urandom);
                    b = 16'($urandom);
                end
            endcase
            send_pair(a, b);
        end
    endtask

    initial begin
        logic [31:0] means[5];
        logic [31:0] stds[5];
        i_rst_n           = 1'b0;
        calm              = 1'b0;
        hold_cnt          = 0;
        pair_ch.valid     = 1'b0;
        pair_ch.uniform_a = '0;
        pair_ch.uniform_b = '0;
        cfg_ch.valid      = 1'b0;
        cfg_ch.index      = '0;
        cfg_ch.data       = '0;
        sample_ch.ready   = 1'b0;
        repeat (4) @(negedge i_clk);
        i_rst_n = 1'b1;

        // corners at reset settings
        send_pair(16'h0000, 16'h8000);
        send_pair(16'h8000, 16'h8000);
        send_pair(16'hFFFF, 16'hFFFF);
        send_pair(16'h0001, 16'h0001);
        send_pair(16'h8000, 16'h0001);
        send_pair(16'h8000, 16'hFFFF);
        send_pair(16'h8001, 16'h8000);
        send_pair(16'h8000, 16'h7FFF);
        send_pair(16'h8001, 16'h8001);
        send_pair(16'h5A82, 16'hA57E);
        send_pair(16'h4000, 16'hC000);
        drain();
        write_reg(8'd5, 32'hDEAD_BEEF);
        write_reg(gpbm_pkg::REG_MEAN, 32'h7FFF_FFFF);
        write_reg(gpbm_pkg::REG_STD_DEV, 32'hFFFF_FFFF);
        send_pair(16'h8001, 16'h8000);
        send_pair(16'h7FFF, 16'h8001);
        send_pair(16'h8000, 16'h0001);
        drain();
        write_reg(gpbm_pkg::REG_MEAN, 32'h8000_0000);
        send_pair(16'h7FFF, 16'h8001);
        send_pair(16'h0001, 16'h8000);
        drain();
        write_reg(gpbm_pkg::REG_STD_DEV, 32'h0000_0000);
        send_pair(16'h3000, 16'h9000);
        drain();

        means = '{32'h0000_0000, $urandom, 32'h7FFF_FFFF, 32'h8000_0000, $urandom};
        stds  = '{32'h0001_0000, $urandom, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                  32'($urandom_range(0, 32'h0004_0000))};
        for (int ph = 0; ph < 5; ph++) begin
            write_reg(gpbm_pkg::REG_MEAN, means[ph]);
            write_reg(gpbm_pkg::REG_STD_DEV, stds[ph]);
            if (ph == 4) calm = 1'b1;
            random_pairs(320);
            drain();
        end

        if (errors == 0) begin
            $display("gaussian_polar_box_muller regression: pass");
        end else begin
            $display("gaussian_polar_box_muller regression: fail");
        end
        $finish;
    end

endmodule

`default_nettype wire

// ===== sim.f =====
+incdir+rtl/core
rtl/core/gpbm_pkg.sv
rtl/core/gpbm_if.sv
rtl/core/gpbm_log_div_stage.sv
rtl/core/gpbm_root_stage.sv
rtl/core/gaussian_polar_box_muller.sv
sim/gaussian_polar_box_muller_checker.sv
sim/gaussian_polar_box_muller_test.sv
